// ===== rtl/ordered_array_insert_erase_engine_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered array engine
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_ARRAY_INSERT_ERASE_ENGINE_ASSERT_SVH
`define ORDERED_ARRAY_INSERT_ERASE_ENGINE_ASSERT_SVH

// Same-cycle implication
`define OAIE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define OAIE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/oaie_pkg.sv =====
// ----------------------------------------------------------------------------
// oaie_pkg
// Sizes, request and status codes, and the command bundle broadcast to cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oaie_pkg;

	localparam int DEPTH      = 32;
	localparam int WORD_WIDTH = 32;

	// Field widths of the stream items
	localparam int MODE_W   = 3;
	localparam int POS_W    = 6;
	localparam int LAST_W   = 5;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 6;

	localparam int IN_BITS  = MODE_W + POS_W + LAST_W + DATA_W;
	localparam int OUT_BITS = STATUS_W + COUNT_W + 3 * DATA_W;
	localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

	// Internal widths
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH   = 3'd0,
		MODE_POP    = 3'd1,
		MODE_INSERT = 3'd2,
		MODE_ERASE  = 3'd3,
		MODE_READ   = 3'd4,
		MODE_CLEAR  = 3'd5
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK     = 3'd0,
		STAT_BOUNDS = 3'd1,
		STAT_RANGE  = 3'd2,
		STAT_FULL   = 3'd3,
		STAT_EMPTY  = 3'd4
	} status_t;

	// What each cell does in the current cycle
	typedef enum logic [1:0] {
		CELL_HOLD   = 2'd0,
		CELL_PUSH   = 2'd1,
		CELL_INSERT = 2'd2,
		CELL_SHIFT  = 2'd3
	} cell_op_t;

	// Broadcast to every cell; pos and count also steer the read taps
	typedef struct packed {
		cell_op_t                op;
		logic [CMP_W-1:0]        pos;
		logic [CNT_W-1:0]        count;
		logic [WORD_WIDTH-1:0]   value;
	} cell_cmd_t;

	// Sequencer to result register
	typedef struct packed {
		logic    fire;
		status_t status;
		logic    rd_en;
	} report_t;

endpackage

// ===== rtl/oaie_cell.sv =====
// ----------------------------------------------------------------------------
// oaie_cell
// One storage cell of the array: loads, takes a neighbor's word, or holds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oaie_cell (
	input  logic                         clk,
	input  logic [oaie_pkg::IDX_W-1:0]      idx,
	input  oaie_pkg::cell_cmd_t          cmd,
	input  logic [oaie_pkg::WORD_WIDTH-1:0] left_word,
	input  logic [oaie_pkg::WORD_WIDTH-1:0] right_word,
	output logic [oaie_pkg::WORD_WIDTH-1:0] word,
	output logic [oaie_pkg::WORD_WIDTH-1:0] rd_tap,
	output logic [oaie_pkg::WORD_WIDTH-1:0] back_tap
);
	import oaie_pkg::*;

	logic [CMP_W-1:0]      idx_c;
	logic [WORD_WIDTH-1:0] word_q;
	logic [WORD_WIDTH-1:0] word_d;

	assign idx_c = CMP_W'(idx);

	// Select next word from the broadcast command
	always_comb begin
		word_d = word_q;
		case (cmd.op)
			CELL_PUSH: begin
				if (idx_c == CMP_W'(cmd.count)) word_d = cmd.value;
			end
			CELL_INSERT: begin
				if (idx_c == cmd.pos) word_d = cmd.value;
				else if (idx_c > cmd.pos) word_d = left_word;
			end
			CELL_SHIFT: begin
				if (idx_c >= cmd.pos) word_d = right_word;
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	// Drive taps only when this cell is addressed
	assign word     = word_q;
	assign rd_tap   = (idx_c == cmd.pos) ? word_q : '0;
	assign back_tap = (idx_c + CMP_W'(1) == CMP_W'(cmd.count)) ? word_q : '0;

endmodule

// ===== rtl/oaie_seq.sv =====
// ----------------------------------------------------------------------------
// oaie_seq
// Request decoder and sequencer: checks bounds, keeps the count, drives cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oaie_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [oaie_pkg::MODE_W-1:0] in_mode,
	input  logic [oaie_pkg::POS_W-1:0]  in_pos,
	input  logic [oaie_pkg::LAST_W-1:0] in_last,
	input  logic [oaie_pkg::DATA_W-1:0] in_value,
	input  logic                      out_free,
	output oaie_pkg::cell_cmd_t       cmd,
	output oaie_pkg::report_t         report
);
	import oaie_pkg::*;

	`include "ordered_array_insert_erase_engine_assert.svh"

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SHIFT  = 3'b010,
		ST_REPORT = 3'b100
	} seq_state_t;

	seq_state_t       state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] rem_q;
	logic [CMP_W-1:0] pos_q;
	status_t          status_q;
	logic             rd_en_q;

	logic             accept;
	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] last_c;
	logic [CMP_W-1:0] cnt_c;
	logic             full;
	logic [CNT_W-1:0] gap;
	status_t          status_d;
	logic [CNT_W-1:0] count_d;
	logic             rd_en_d;
	logic             erase_go;
	cell_op_t         op_d;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	assign pos_c  = CMP_W'(in_pos);
	assign last_c = CMP_W'(in_last);
	assign cnt_c  = CMP_W'(count_q);
	assign full   = (count_q == CNT_W'(DEPTH));
	assign gap    = CNT_W'(last_c - pos_c + CMP_W'(1));

	// Decode the request against the current count
	always_comb begin
		status_d = STAT_OK;
		count_d  = count_q;
		rd_en_d  = 1'b0;
		erase_go = 1'b0;
		op_d     = CELL_HOLD;
		case (in_mode)
			MODE_PUSH: begin
				if (full) status_d = STAT_FULL;
				else begin
					op_d    = CELL_PUSH;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_POP: begin
				if (count_q == '0) status_d = STAT_EMPTY;
				else count_d = count_q - CNT_W'(1);
			end
			MODE_INSERT: begin
				if (pos_c > cnt_c) status_d = STAT_BOUNDS;
				else if (full) status_d = STAT_FULL;
				else begin
					op_d    = CELL_INSERT;
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_ERASE: begin
				if (pos_c >= cnt_c || last_c >= cnt_c) status_d = STAT_BOUNDS;
				else if (pos_c > last_c) status_d = STAT_RANGE;
				else begin
					erase_go = 1'b1;
					count_d  = count_q - gap;
				end
			end
			MODE_READ: begin
				if (pos_c >= cnt_c) status_d = STAT_BOUNDS;
				else rd_en_d = 1'b1;
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// Sequence: accept, shift down once per erased entry, then report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			rem_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= count_d;
						rem_q   <= gap;
						state_q <= erase_go ? ST_SHIFT : ST_REPORT;
					end
				end
				ST_SHIFT: begin
					rem_q <= rem_q - CNT_W'(1);
					if (rem_q == CNT_W'(1)) state_q <= ST_REPORT;
				end
				ST_REPORT: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Hold the request details for the shift and report cycles
	always_ff @(posedge clk) begin
		if (accept) begin
			pos_q    <= pos_c;
			status_q <= status_d;
			rd_en_q  <= rd_en_d;
		end
	end

	// Broadcast to the cell row
	always_comb begin
		cmd.value = WORD_WIDTH'(in_value);
		if (state_q == ST_IDLE) begin
			cmd.op    = accept ? op_d : CELL_HOLD;
			cmd.pos   = pos_c;
			cmd.count = count_q;
		end else begin
			cmd.op    = (state_q == ST_SHIFT) ? CELL_SHIFT : CELL_HOLD;
			cmd.pos   = pos_q;
			cmd.count = count_q;
		end
	end

	assign report.fire   = (state_q == ST_REPORT) && out_free;
	assign report.status = status_q;
	assign report.rd_en  = rd_en_q;

	`OAIE_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH),
		"count above capacity")
	`OAIE_ASSERT_NEXT(a_count_only_on_accept, !accept, $stable(count_q),
		"count changed without a transaction")
	`OAIE_ASSERT_NOW(a_shift_pending, state_q == ST_SHIFT, rem_q != '0,
		"shift state with nothing left to shift")

endmodule

// ===== rtl/ordered_array_insert_erase_engine.sv =====
// ----------------------------------------------------------------------------
// ordered_array_insert_erase_engine
// Ordered array of up to DEPTH words in a row of shifting cells, with push,
// pop, insert, range erase, read and clear requests and one result each.
// ----------------------------------------------------------------------------
// Sequence: a request is accepted in the idle state and its result is loaded
// into the output register in the report state once that register is free;
// the input is not ready again until the report is done. An erase of N entries
// first moves the cell row down one place per cycle, once per erased entry. The
// output register holds one finished result while the next request is taken;
// a result that still waits when the following one is ready stalls the report
// cycle. No clearing pass is needed after reset: only entries below the count are ever read.
`timescale 1ns / 1ps

module ordered_array_insert_erase_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// mode, position, last_position, value
	input  logic [oaie_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// status, element_count, read_value, front_value, back_value
	output logic [oaie_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
	import oaie_pkg::*;

	localparam int P_POS  = MODE_W;
	localparam int P_LAST = P_POS + POS_W;
	localparam int P_VAL  = P_LAST + LAST_W;

	cell_cmd_t             cmd;
	report_t               report;
	logic                  out_free;
	logic [WORD_WIDTH-1:0] words     [DEPTH];
	logic [WORD_WIDTH-1:0] rd_taps   [DEPTH];
	logic [WORD_WIDTH-1:0] back_taps [DEPTH];
	logic [WORD_WIDTH-1:0] rd_word;
	logic [WORD_WIDTH-1:0] back_word;
	logic [WORD_WIDTH-1:0] front_word;
	logic                  m_valid_q;
	logic [OUT_BITS-1:0]   m_data_q;

	oaie_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_mode  (s_axis_tdata[MODE_W-1:0]),
		.in_pos   (s_axis_tdata[P_POS +: POS_W]),
		.in_last  (s_axis_tdata[P_LAST +: LAST_W]),
		.in_value (s_axis_tdata[P_VAL +: DATA_W]),
		.out_free (out_free),
		.cmd      (cmd),
		.report   (report)
	);

	// Row of cells, each fed by its neighbors
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w;
		logic [WORD_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = words[i];
		end else begin : g_mid_r
			assign right_w = words[i+1];
		end

		oaie_cell u_cell (
			.clk        (clk),
			.idx        (IDX_W'(i)),
			.cmd        (cmd),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[i]),
			.rd_tap     (rd_taps[i]),
			.back_tap   (back_taps[i])
		);
	end

	// Merge the addressed taps
	always_comb begin
		rd_word   = '0;
		back_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word   = rd_word | rd_taps[i];
			back_word = back_word | back_taps[i];
		end
	end

	assign front_word = (cmd.count != '0) ? words[0] : '0;

	// Output register: load on report, drop when taken
	assign out_free = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (report.fire) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (report.fire) begin
			m_data_q <= {DATA_W'(back_word),
				DATA_W'(front_word),
				report.rd_en ? DATA_W'(rd_word) : DATA_W'(0),
				COUNT_W'(cmd.count),
				report.status};
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = OUT_TDATA_W'(m_data_q);

endmodule

// ===== tb/tb_ordered_array_insert_erase_engine.sv =====
// ----------------------------------------------------------------------------
// Testbench for the ordered array insert/erase engine
// Streams push, pop, insert, erase, read, clear and unused-mode requests into
// the block, predicts every result from a local copy of the array, and checks
// each result transaction field by field in order. A directed table covers the
// error cases and the extremes; a biased random part follows, with random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_ordered_array_insert_erase_engine;

	import oaie_pkg::*;

	// Modes the block leaves unused
	localparam logic [MODE_W-1:0] MODE_UNUSED_LO = 3'd6;
	localparam logic [MODE_W-1:0] MODE_UNUSED_HI = 3'd7;

	localparam int RANDOM_ITEMS = 800;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_AFTER   = 300;
	localparam int HOLD_CYCLES  = 250;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [POS_W-1:0]  pos;
		logic [LAST_W-1:0] last;
		logic [DATA_W-1:0] value;
	} array_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
		logic [DATA_W-1:0]   rd;
		logic [DATA_W-1:0]   front;
		logic [DATA_W-1:0]   back;
	} array_res_t;

	typedef struct {
		array_req_t req;
		int         reps;
		bit         typed;
		array_res_t res;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n        = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// mode, position, last_position, value
	logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// status, element_count, read_value, front_value, back_value
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	// Local copy of the array
	logic [WORD_WIDTH-1:0] element_copy [DEPTH];
	int                    copy_count = 0;

	array_res_t expected_results [$];
	int         mismatches   = 0;
	int         results_seen = 0;
	bit         calm         = 1'b0;

	ordered_array_insert_erase_engine i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold reset at start, then release it
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Apply one request to the local copy and return the result it gives
	function automatic array_res_t step_array(array_req_t r);
		array_res_t e;
		int p;
		int l;
		int span;
		e = '0;
		e.status = STAT_OK;
		p = int'(r.pos);
		l = int'(r.last);
		case (r.mode)
			MODE_PUSH: begin
				if (copy_count >= DEPTH) begin
					e.status = STAT_FULL;
				end else begin
					element_copy[copy_count] = r.value;
					copy_count++;
				end
			end
			MODE_POP: begin
				if (copy_count == 0) e.status = STAT_EMPTY;
				else copy_count--;
			end
			MODE_INSERT: begin
				if (p > copy_count) begin
					e.status = STAT_BOUNDS;
				end else if (copy_count >= DEPTH) begin
					e.status = STAT_FULL;
				end else begin
					for (int i = copy_count; i > p; i--) element_copy[i] = element_copy[i-1];
					element_copy[p] = r.value;
					copy_count++;
				end
			end
			MODE_ERASE: begin
				if (p >= copy_count || l >= copy_count) begin
					e.status = STAT_BOUNDS;
				end else if (p > l) begin
					e.status = STAT_RANGE;
				end else begin
					span = l - p + 1;
					for (int i = p; i + span < copy_count; i++)
						element_copy[i] = element_copy[i+span];
					copy_count -= span;
				end
			end
			MODE_READ: begin
				if (p >= copy_count) e.status = STAT_BOUNDS;
				else e.rd = element_copy[p];
			end
			MODE_CLEAR: copy_count = 0;
			default: ;
		endcase
		e.count = copy_count[COUNT_W-1:0];
		if (copy_count != 0) begin
			e.front = element_copy[0];
			e.back  = element_copy[copy_count-1];
		end
		return e;
	endfunction

	// Idle length: mostly none or short, a few long
	function automatic int idle_len();
		int pick;
		pick = $urandom_range(99);
		if (pick < 65) return 0;
		if (pick < 88) return $urandom_range(1, 3);
		if (pick < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Mostly well-formed requests against the current count, some noise
	function automatic array_req_t random_request(bit grow);
		array_req_t r;
		int pick;
		int first;
		int reach;
		r.value = $urandom;
		r.pos   = POS_W'($urandom);
		r.last  = LAST_W'($urandom);
		pick = $urandom_range(99);
		if ($urandom_range(15) == 0) r.value = ($urandom_range(1) != 0) ? '1 : '0;
		if (grow) begin
			if (pick < 40) r.mode = MODE_PUSH;
			else if (pick < 64) r.mode = MODE_INSERT;
			else if (pick < 72) r.mode = MODE_POP;
			else if (pick < 80) r.mode = MODE_ERASE;
			else if (pick < 96) r.mode = MODE_READ;
			else if (pick < 97) r.mode = MODE_CLEAR;
			else r.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		end else begin
			if (pick < 15) r.mode = MODE_PUSH;
			else if (pick < 25) r.mode = MODE_INSERT;
			else if (pick < 44) r.mode = MODE_POP;
			else if (pick < 69) r.mode = MODE_ERASE;
			else if (pick < 92) r.mode = MODE_READ;
			else if (pick < 95) r.mode = MODE_CLEAR;
			else r.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		end
		case (r.mode)
			MODE_INSERT: begin
				if ($urandom_range(99) < 85) r.pos = POS_W'($urandom_range(0, copy_count));
			end
			MODE_READ: begin
				if (copy_count > 0 && $urandom_range(99) < 85)
					r.pos = POS_W'($urandom_range(0, copy_count - 1));
			end
			MODE_ERASE: begin
				if (copy_count > 0 && $urandom_range(99) < 80) begin
					first = $urandom_range(0, copy_count - 1);
					reach = copy_count - 1 - first;
					if (reach > 6 && $urandom_range(9) != 0) reach = 6;
					r.pos  = POS_W'(first);
					r.last = LAST_W'(first + int'($urandom_range(0, reach)));
				end else if ($urandom_range(1) != 0) begin
					r.pos = POS_W'($urandom_range(0, DEPTH + 1));
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	function automatic dir_row_t mk_row(logic [MODE_W-1:0] mode, int pos, int last,
			logic [DATA_W-1:0] value, int reps, bit typed,
			logic [STATUS_W-1:0] st, int cnt, logic [DATA_W-1:0] rd,
			logic [DATA_W-1:0] front, logic [DATA_W-1:0] back);
		dir_row_t row;
		row.req.mode  = mode;
		row.req.pos   = pos[POS_W-1:0];
		row.req.last  = last[LAST_W-1:0];
		row.req.value = value;
		row.reps      = reps;
		row.typed     = typed;
		row.res.status = st;
		row.res.count  = cnt[COUNT_W-1:0];
		row.res.rd     = rd;
		row.res.front  = front;
		row.res.back   = back;
		return row;
	endfunction

	// Offer one request and wait until it is taken
	task automatic offer(array_req_t r);
		int gap;
		gap = calm ? 0 : idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {{(IN_TDATA_W - IN_BITS){1'b0}}, r.value, r.last, r.pos, r.mode};
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Drive the directed table, then the random part, then drain
	initial begin
		dir_row_t   dir_rows [$];
		dir_row_t   row;
		array_req_t r;
		array_res_t pred;
		dir_rows.push_back(mk_row(MODE_POP,    0,  0, 0, 1, 1, STAT_EMPTY,  0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_ERASE,  0,  0, 0, 1, 1, STAT_BOUNDS, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_READ,   0,  0, 0, 1, 1, STAT_BOUNDS, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_PUSH,   0,  0, '1, 1, 1, STAT_OK, 1, 0, '1, '1));
		dir_rows.push_back(mk_row(MODE_PUSH,   0,  0, 0, 1, 1, STAT_OK, 2, 0, '1, 0));
		dir_rows.push_back(mk_row(MODE_READ,   0,  0, 0, 1, 1, STAT_OK, 2, '1, '1, 0));
		// Insert beyond the count
		dir_rows.push_back(mk_row(MODE_INSERT, 63, 0, 5, 1, 1, STAT_BOUNDS, 2, 0, '1, 0));
		dir_rows.push_back(mk_row(MODE_INSERT, 3,  0, 5, 1, 1, STAT_BOUNDS, 2, 0, '1, 0));
		// Insert at the count appends, insert at zero prepends
		dir_rows.push_back(mk_row(MODE_INSERT, 2,  0, 32'h1234_5678, 1, 1, STAT_OK, 3, 0,
			'1, 32'h1234_5678));
		dir_rows.push_back(mk_row(MODE_INSERT, 0,  0, 32'hA5A5_A5A5, 1, 1, STAT_OK, 4, 0,
			32'hA5A5_A5A5, 32'h1234_5678));
		// First above last, then last past the count
		dir_rows.push_back(mk_row(MODE_ERASE,  2,  1, 0, 1, 1, STAT_RANGE, 4, 0,
			32'hA5A5_A5A5, 32'h1234_5678));
		dir_rows.push_back(mk_row(MODE_ERASE,  1, 31, 0, 1, 1, STAT_BOUNDS, 4, 0,
			32'hA5A5_A5A5, 32'h1234_5678));
		dir_rows.push_back(mk_row(MODE_ERASE,  1,  2, 0, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_READ,  32,  0, 0, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_UNUSED_LO, 5, 3, '1, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_UNUSED_HI, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_CLEAR,  0,  0, 0, 1, 1, STAT_OK, 0, 0, 0, 0));
		// Fill the store, then hit it while full
		dir_rows.push_back(mk_row(MODE_PUSH,   0,  0, 32'h8000_0000, DEPTH, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_PUSH,   0,  0, 32'hDEAD_0001, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_INSERT, 32, 0, 32'hDEAD_0002, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_INSERT, 33, 0, 32'hDEAD_0003, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_INSERT, 0,  0, 32'hDEAD_0004, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_READ,  31,  0, 0, 1, 0, 0, 0, 0, 0, 0));
		// Erase the top entry, then everything that is left
		dir_rows.push_back(mk_row(MODE_ERASE, 31, 31, 0, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_ERASE,  0, 30, 0, 1, 0, 0, 0, 0, 0, 0));
		dir_rows.push_back(mk_row(MODE_READ,  63,  0, 0, 1, 1, STAT_BOUNDS, 0, 0, 0, 0));

		do @(posedge clk); while (!arst_n);
		@(posedge clk);

		foreach (dir_rows[n]) begin
			row = dir_rows[n];
			for (int k = 0; k < row.reps; k++) begin
				r = row.req;
				r.value = r.value + k;
				offer(r);
				pred = step_array(r);
				expected_results.push_back(row.typed ? row.res : pred);
			end
		end

		// Alternate growing and shrinking phases; one stretch runs without idling
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 400 && n < 550);
			r = random_request(((n / 90) % 2) == 0);
			offer(r);
			pred = step_array(r);
			expected_results.push_back(pred);
		end
		s_axis_tvalid <= 1'b0;

		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Check each result transaction and drive the output-side stalls
	initial begin
		array_res_t got;
		array_res_t want;
		int         stall_left;
		int         hold_left;
		bit         held;
		stall_left = 0;
		hold_left  = 0;
		held       = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tdata[2:0];
				got.count  = m_axis_tdata[8:3];
				got.rd     = m_axis_tdata[40:9];
				got.front  = m_axis_tdata[72:41];
				got.back   = m_axis_tdata[104:73];
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d count %0d rd %h front %h back %h",
							got.status, got.count, got.rd, got.front, got.back);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d mismatch: status %0d/%0d count %0d/%0d rd %h/%h",
								results_seen, want.status, got.status, want.count, got.count,
								want.rd, got.rd);
							$display("  front %h/%h back %h/%h (expected/actual)",
								want.front, got.front, want.back, got.back);
						end
					end
				end
			end
			// Hold off once for a long stretch so the input backs up
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (!held && results_seen >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready <= 1'b0;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else if (!calm && $urandom_range(99) < 25) begin
				stall_left = idle_len();
				if (stall_left > 0) begin
					m_axis_tready <= 1'b0;
					stall_left--;
				end else begin
					m_axis_tready <= 1'b1;
				end
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// End the run if it stalls
	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

endmodule
